[src/rk4_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the RK4 step core.
package rk4_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned WIDE_W    = DATA_W + 3;
  localparam int unsigned DIG_W     = 8;
  localparam int unsigned DIV_W     = 5 * DIG_W;

  typedef logic signed [DATA_W-1:0] fx_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam fx_t FX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam fx_t TWO_FX = DATA_W'(2) << FRAC_BITS;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1) << FRAC_BITS;

  // Rounding bias for the final divide by six.
  localparam wide_t SUM_BIAS = wide_t'(3);
  // The halved sum is shifted positive by three times 2^(WIDE_W-2), so the
  // quotient carries an offset of 2^(WIDE_W-2).
  localparam logic [WIDE_W-1:0] DIV_OFFSET = WIDE_W'(3) << (WIDE_W - 2);
  localparam logic [WIDE_W-1:0] QUO_OFFSET = WIDE_W'(1) << (WIDE_W - 2);

  localparam logic [19:0] DIV3_RECIP = 20'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  typedef struct packed {
    fx_t  val;
    logic sat;
  } fx_sat_t;

  typedef struct packed {
    fx_t y;
    fx_t xxm;
    fx_t xxe;
    fx_t k1;
    fx_t k2;
    fx_t k3;
  } side_t;

  typedef struct packed {
    logic prod;
    logic slope;
    logic hprod;
    logic kval;
  } kst_en_t;

  typedef struct packed {
    logic [DIG_W-1:0] quo;
    logic [1:0]       rem;
  } div3_t;

  // Clip a wide signed value to the 32-bit range.
  function automatic fx_sat_t fx_clip(input wide_t v);
    fx_sat_t r;
    r.sat = 1'b0;
    r.val = v[DATA_W-1:0];
    if (v > wide_t'(FX_MAX)) begin
      r.sat = 1'b1;
      r.val = FX_MAX;
    end else if (v < wide_t'(FX_MIN)) begin
      r.sat = 1'b1;
      r.val = FX_MIN;
    end
    return r;
  endfunction

  // Round a full product to nearest (ties upwards), drop the fraction and clip.
  function automatic fx_sat_t fx_round(input prod_t p);
    prod_t   s;
    fx_sat_t r;
    s     = (p + (prod_t'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    r.sat = !((&s[PROD_W-1:DATA_W-1]) || !(|s[PROD_W-1:DATA_W-1]));
    if (r.sat) begin
      r.val = s[PROD_W-1] ? FX_MIN : FX_MAX;
    end else begin
      r.val = s[DATA_W-1:0];
    end
    return r;
  endfunction

  function automatic fx_sat_t fx_add(input fx_t a, input fx_t b);
    return fx_clip(wide_t'(a) + wide_t'(b));
  endfunction

  // One radix-256 digit of a long division by three.
  function automatic div3_t div3_digit(input logic [1:0] rem, input logic [DIG_W-1:0] dig);
    logic [9:0]  n;
    logic [19:0] m;
    div3_t       r;
    n     = {rem, dig};
    m     = 20'(n) * DIV3_RECIP;
    r.quo = m[DIV3_SHIFT +: DIG_W];
    r.rem = 2'(n - 10'(r.quo) * 10'd3);
    return r;
  endfunction

endpackage

[src/rk4_kstage.sv]
`timescale 1ns / 1ps
// One k evaluation: k = h * (xsq * y - 2), four register stages.
module rk4_kstage (
  input  logic                           clk_i,
  input  rk4_pkg::kst_en_t               en_i,
  input  logic [rk4_pkg::STEP_W-1:0]     h_i,
  input  rk4_pkg::fx_t                   xsq_i,
  input  rk4_pkg::fx_t                   y_i,
  input  logic                           sat_i,
  input  rk4_pkg::side_t                 side_i,
  output rk4_pkg::fx_t                   k_o,
  output logic                           sat_o,
  output rk4_pkg::side_t                 side_o
);

  rk4_pkg::prod_t   prod_q;
  rk4_pkg::prod_t   hprod_q;
  rk4_pkg::fx_t     slope_q;
  rk4_pkg::fx_t     k_q;
  logic [3:0]       sat_q;
  rk4_pkg::side_t   side1_q, side2_q, side3_q, side4_q;

  rk4_pkg::fx_sat_t xxy_r;
  rk4_pkg::fx_sat_t slope_r;
  rk4_pkg::fx_sat_t k_r;

  always_comb begin
    xxy_r   = rk4_pkg::fx_round(prod_q);
    slope_r = rk4_pkg::fx_clip(rk4_pkg::wide_t'(xxy_r.val) - rk4_pkg::wide_t'(rk4_pkg::TWO_FX));
    k_r     = rk4_pkg::fx_round(hprod_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q   <= rk4_pkg::prod_t'(xsq_i) * rk4_pkg::prod_t'(y_i);
      sat_q[0] <= sat_i;
      side1_q  <= side_i;
    end
    if (en_i.slope) begin
      slope_q  <= slope_r.val;
      sat_q[1] <= sat_q[0] | xxy_r.sat | slope_r.sat;
      side2_q  <= side1_q;
    end
    if (en_i.hprod) begin
      hprod_q  <= rk4_pkg::prod_t'($signed({1'b0, h_i})) * rk4_pkg::prod_t'(slope_q);
      sat_q[2] <= sat_q[1];
      side3_q  <= side2_q;
    end
    if (en_i.kval) begin
      k_q      <= k_r.val;
      sat_q[3] <= sat_q[2] | k_r.sat;
      side4_q  <= side3_q;
    end
  end

  assign k_o    = k_q;
  assign sat_o  = sat_q[3];
  assign side_o = side4_q;

endmodule

[src/rk4_ode_step_core.sv]
`timescale 1ns / 1ps
// Top level of the pipelined RK4 increment core for y' = x*x*y - 2.
//
// Usage: each input beat carries a point (x_value_i, y_value_i) in signed
// Q16.16 and yields exactly one output beat with the increment delta_y_o and
// a flag saturated_o that is set when any intermediate or the result was
// clipped to the 32-bit range. Both channels use valid/ready; a beat moves
// when valid and ready are high together. The step size h is written through
// cfg_we_i/cfg_wdata_i and must only be changed while the pipeline is empty.
//
// Structure and throughput: the datapath is a 25-stage pipeline with one
// register behind every multiplier (eleven 32x32 multipliers in total, each
// used once per beat), so one beat can enter and leave every cycle while the
// receiver is ready.
//
// Reset clears all stage valid bits and loads h = 1.0. When the receiver
// stalls, results hold in place and beats behind them close up into any
// empty stages, so input is still taken until every stage is full. Nothing
// is dropped or repeated.
module rk4_ode_step_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rk4_pkg::STEP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [31:0]         x_value_i,
  input  logic signed [31:0]         y_value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         delta_y_o,
  output logic                       saturated_o
);

  // Stage map of the pipeline.
  localparam int unsigned NSTG    = 25;
  localparam int unsigned ST_IN   = 0;   // midpoint and endpoint x
  localparam int unsigned ST_SQ   = 1;   // three squares of x
  localparam int unsigned ST_SQR  = 2;   // squares rounded
  localparam int unsigned ST_K1   = 3;   // k1, four stages
  localparam int unsigned ST_Y2   = 7;
  localparam int unsigned ST_K2   = 8;
  localparam int unsigned ST_Y3   = 12;
  localparam int unsigned ST_K3   = 13;
  localparam int unsigned ST_Y4   = 17;
  localparam int unsigned ST_K4   = 18;
  localparam int unsigned ST_SUM  = 22;  // weighted sum, offset for division
  localparam int unsigned ST_DIVH = 23;  // upper quotient digits
  localparam int unsigned ST_OUT  = 24;  // lower digits, clip, output register

  // Step size register.
  logic [rk4_pkg::STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rk4_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  // Valid bits and stage enables. A stage may load whenever some stage at or
  // after it is empty, or the receiver takes the result; this lets bubbles
  // close up while the output is stalled.
  logic [NSTG-1:0] vld_q, vld_d, vld_prev;
  logic [NSTG-1:0] rdy;

  for (genvar g = 0; g < NSTG; g++) begin : g_rdy
    assign rdy[g] = out_ready_i || !(&vld_q[NSTG-1:g]);
  end

  assign vld_prev = {vld_q[NSTG-2:0], in_valid_i};
  assign vld_d    = (rdy & vld_prev) | (~rdy & vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = rdy[ST_IN];
  assign out_valid_o = vld_q[ST_OUT];

  // Input stage: the two shifted abscissae x + h/2 and x + h.
  rk4_pkg::fx_sat_t xm_r, xe_r;
  rk4_pkg::fx_t     a_x_q, a_y_q, a_xm_q, a_xe_q;
  logic             a_sat_q;

  always_comb begin
    xm_r = rk4_pkg::fx_add(x_value_i, rk4_pkg::fx_t'({2'b00, step_q[rk4_pkg::STEP_W-1:1]}));
    xe_r = rk4_pkg::fx_add(x_value_i, rk4_pkg::fx_t'({1'b0, step_q}));
  end

  // Squares: x*x serves k1, the midpoint square serves k2 and k3, the
  // endpoint square serves k4.
  rk4_pkg::prod_t   b_xx_q, b_xxm_q, b_xxe_q;
  rk4_pkg::fx_t     b_y_q;
  logic             b_sat_q;

  rk4_pkg::fx_sat_t xx_r, xxm_r, xxe_r;
  rk4_pkg::fx_t     c_xx_q;
  rk4_pkg::side_t   c_side_q, c_side_d;
  logic             c_sat_q;

  always_comb begin
    xx_r           = rk4_pkg::fx_round(b_xx_q);
    xxm_r          = rk4_pkg::fx_round(b_xxm_q);
    xxe_r          = rk4_pkg::fx_round(b_xxe_q);
    c_side_d       = '0;
    c_side_d.y     = b_y_q;
    c_side_d.xxm   = xxm_r.val;
    c_side_d.xxe   = xxe_r.val;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) begin
      a_x_q   <= x_value_i;
      a_y_q   <= y_value_i;
      a_xm_q  <= xm_r.val;
      a_xe_q  <= xe_r.val;
      a_sat_q <= xm_r.sat | xe_r.sat;
    end
    if (rdy[ST_SQ]) begin
      b_xx_q  <= rk4_pkg::prod_t'(a_x_q) * rk4_pkg::prod_t'(a_x_q);
      b_xxm_q <= rk4_pkg::prod_t'(a_xm_q) * rk4_pkg::prod_t'(a_xm_q);
      b_xxe_q <= rk4_pkg::prod_t'(a_xe_q) * rk4_pkg::prod_t'(a_xe_q);
      b_y_q   <= a_y_q;
      b_sat_q <= a_sat_q;
    end
    if (rdy[ST_SQR]) begin
      c_xx_q   <= xx_r.val;
      c_side_q <= c_side_d;
      c_sat_q  <= b_sat_q | xx_r.sat | xxm_r.sat | xxe_r.sat;
    end
  end

  // The four k evaluations, with the y update between each pair.
  rk4_pkg::kst_en_t k1_en, k2_en, k3_en, k4_en;
  rk4_pkg::fx_t     k1_k, k2_k, k3_k, k4_k;
  logic             k1_sat, k2_sat, k3_sat, k4_sat;
  rk4_pkg::side_t   k1_side, k2_side, k3_side, k4_side;

  always_comb begin
    k1_en.prod  = rdy[ST_K1];
    k1_en.slope = rdy[ST_K1+1];
    k1_en.hprod = rdy[ST_K1+2];
    k1_en.kval  = rdy[ST_K1+3];
    k2_en.prod  = rdy[ST_K2];
    k2_en.slope = rdy[ST_K2+1];
    k2_en.hprod = rdy[ST_K2+2];
    k2_en.kval  = rdy[ST_K2+3];
    k3_en.prod  = rdy[ST_K3];
    k3_en.slope = rdy[ST_K3+1];
    k3_en.hprod = rdy[ST_K3+2];
    k3_en.kval  = rdy[ST_K3+3];
    k4_en.prod  = rdy[ST_K4];
    k4_en.slope = rdy[ST_K4+1];
    k4_en.hprod = rdy[ST_K4+2];
    k4_en.kval  = rdy[ST_K4+3];
  end

  rk4_kstage u_k1 (
    .clk_i  (clk_i),
    .en_i   (k1_en),
    .h_i    (step_q),
    .xsq_i  (c_xx_q),
    .y_i    (c_side_q.y),
    .sat_i  (c_sat_q),
    .side_i (c_side_q),
    .k_o    (k1_k),
    .sat_o  (k1_sat),
    .side_o (k1_side)
  );

  // y + k1/2 for the first midpoint.
  rk4_pkg::fx_sat_t y2_r;
  rk4_pkg::side_t   d_side_q, d_side_d;
  rk4_pkg::fx_t     d_y_q;
  logic             d_sat_q;

  always_comb begin
    y2_r        = rk4_pkg::fx_add(k1_side.y, k1_k >>> 1);
    d_side_d    = k1_side;
    d_side_d.k1 = k1_k;
  end

  rk4_kstage u_k2 (
    .clk_i  (clk_i),
    .en_i   (k2_en),
    .h_i    (step_q),
    .xsq_i  (d_side_q.xxm),
    .y_i    (d_y_q),
    .sat_i  (d_sat_q),
    .side_i (d_side_q),
    .k_o    (k2_k),
    .sat_o  (k2_sat),
    .side_o (k2_side)
  );

  // y + k2/2 for the second midpoint.
  rk4_pkg::fx_sat_t y3_r;
  rk4_pkg::side_t   e_side_q, e_side_d;
  rk4_pkg::fx_t     e_y_q;
  logic             e_sat_q;

  always_comb begin
    y3_r        = rk4_pkg::fx_add(k2_side.y, k2_k >>> 1);
    e_side_d    = k2_side;
    e_side_d.k2 = k2_k;
  end

  rk4_kstage u_k3 (
    .clk_i  (clk_i),
    .en_i   (k3_en),
    .h_i    (step_q),
    .xsq_i  (e_side_q.xxm),
    .y_i    (e_y_q),
    .sat_i  (e_sat_q),
    .side_i (e_side_q),
    .k_o    (k3_k),
    .sat_o  (k3_sat),
    .side_o (k3_side)
  );

  // y + k3 for the endpoint.
  rk4_pkg::fx_sat_t y4_r;
  rk4_pkg::side_t   f_side_q, f_side_d;
  rk4_pkg::fx_t     f_y_q;
  logic             f_sat_q;

  always_comb begin
    y4_r        = rk4_pkg::fx_add(k3_side.y, k3_k);
    f_side_d    = k3_side;
    f_side_d.k3 = k3_k;
  end

  rk4_kstage u_k4 (
    .clk_i  (clk_i),
    .en_i   (k4_en),
    .h_i    (step_q),
    .xsq_i  (f_side_q.xxe),
    .y_i    (f_y_q),
    .sat_i  (f_sat_q),
    .side_i (f_side_q),
    .k_o    (k4_k),
    .sat_o  (k4_sat),
    .side_o (k4_side)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[ST_Y2]) begin
      d_side_q <= d_side_d;
      d_y_q    <= y2_r.val;
      d_sat_q  <= k1_sat | y2_r.sat;
    end
    if (rdy[ST_Y3]) begin
      e_side_q <= e_side_d;
      e_y_q    <= y3_r.val;
      e_sat_q  <= k2_sat | y3_r.sat;
    end
    if (rdy[ST_Y4]) begin
      f_side_q <= f_side_d;
      f_y_q    <= y4_r.val;
      f_sat_q  <= k3_sat | y4_r.sat;
    end
  end

  // Weighted sum and floor division by six. The sum is halved (a floor),
  // moved into the positive range, and then divided by three one byte at a
  // time, the upper three bytes in one stage and the lower two in the next.
  rk4_pkg::wide_t             sum_w, half_w;
  logic [rk4_pkg::WIDE_W-1:0] g_u_d, g_u_q;
  logic                       g_sat_q;

  logic [rk4_pkg::DIV_W-1:0]  u_ext;
  rk4_pkg::div3_t             dv4, dv3, dv2, dv1, dv0;
  logic [3*rk4_pkg::DIG_W-1:0] h_qhi_q;
  logic [1:0]                 h_rem_q;
  logic [2*rk4_pkg::DIG_W-1:0] h_lo_q;
  logic                       h_sat_q;

  logic [rk4_pkg::DIV_W-1:0]  quo;
  rk4_pkg::fx_sat_t           res_r;
  rk4_pkg::fx_t               out_q;
  logic                       out_sat_q;

  always_comb begin
    sum_w  = rk4_pkg::wide_t'(k4_side.k1) + (rk4_pkg::wide_t'(k4_side.k2) <<< 1)
           + (rk4_pkg::wide_t'(k4_side.k3) <<< 1) + rk4_pkg::wide_t'(k4_k)
           + rk4_pkg::SUM_BIAS;
    half_w = sum_w >>> 1;
    g_u_d  = rk4_pkg::WIDE_W'(unsigned'(half_w)) + rk4_pkg::DIV_OFFSET;

    u_ext  = {{(rk4_pkg::DIV_W - rk4_pkg::WIDE_W){1'b0}}, g_u_q};
    dv4    = rk4_pkg::div3_digit(2'b00, u_ext[39:32]);
    dv3    = rk4_pkg::div3_digit(dv4.rem, u_ext[31:24]);
    dv2    = rk4_pkg::div3_digit(dv3.rem, u_ext[23:16]);

    dv1    = rk4_pkg::div3_digit(h_rem_q, h_lo_q[15:8]);
    dv0    = rk4_pkg::div3_digit(dv1.rem, h_lo_q[7:0]);
    quo    = {h_qhi_q, dv1.quo, dv0.quo};
    res_r  = rk4_pkg::fx_clip(rk4_pkg::wide_t'(quo[rk4_pkg::WIDE_W-1:0]
                                               - rk4_pkg::QUO_OFFSET));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_SUM]) begin
      g_u_q   <= g_u_d;
      g_sat_q <= k4_sat;
    end
    if (rdy[ST_DIVH]) begin
      h_qhi_q <= {dv4.quo, dv3.quo, dv2.quo};
      h_rem_q <= dv2.rem;
      h_lo_q  <= g_u_q[2*rk4_pkg::DIG_W-1:0];
      h_sat_q <= g_sat_q;
    end
    if (rdy[ST_OUT]) begin
      out_q     <= res_r.val;
      out_sat_q <= h_sat_q | res_r.sat;
    end
  end

  assign delta_y_o   = out_q;
  assign saturated_o = out_sat_q;

  // An accepted beat occupies the first stage on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[ST_IN])
    else $error("accepted input beat did not enter the pipeline");

  // Beats in flight change only by what enters and what leaves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(vld_q) == $past($countones(vld_q))
             + $past(32'(in_valid_i && in_ready_o))
             - $past(32'(out_valid_o && out_ready_i)))
    else $error("pipeline lost or duplicated a beat");

  // The step size leaves reset at 1.0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> step_q == rk4_pkg::STEP_RESET)
    else $error("step size not at its reset value after reset");

endmodule
